### rtl/edeng_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package edeng_pkg;

   localparam int MAX_LEN_DEFAULT     = 64;
   localparam int SYMBOL_BITS_DEFAULT = 16;

   localparam int OP_BITS       = 2;
   localparam int SYMBOL_FIELD  = 16;
   localparam int SYMBOL_WIDE   = 64;
   localparam int DIST_BITS     = 7;
   localparam int DIST_MAX      = 127;

   localparam logic [OP_BITS-1:0] OP_APPEND_FIRST  = 2'd0;
   localparam logic [OP_BITS-1:0] OP_APPEND_SECOND = 2'd1;
   localparam logic [OP_BITS-1:0] OP_COMPUTE       = 2'd2;

   typedef struct packed {
      logic append_first;
      logic append_second;
      logic trivial_load;
      logic compute_start;
      logic row_start;
      logic cell_issue;
      logic next_row;
      logic result_load;
   } ctrl_cmd_type;

   typedef struct packed {
      logic first_empty;
      logic second_empty;
      logic cell_last;
      logic row_last;
   } dpath_status_type;

endpackage

`default_nettype wire

### rtl/edeng_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface edeng_req_if;
   import edeng_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [OP_BITS-1:0]      op;
   logic [SYMBOL_FIELD-1:0] symbol;

   modport source (output valid, output op, output symbol, input ready);
   modport sink   (input valid, input op, input symbol, output ready);
endinterface

interface edeng_rsp_if;
   import edeng_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [DIST_BITS-1:0] distance;
   logic                 overflowed;

   modport source (output valid, output distance, output overflowed, input ready);
   modport sink   (input valid, input distance, input overflowed, output ready);
endinterface

`default_nettype wire

### rtl/edeng_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module edeng_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64,
   localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                 clock,
   input  wire logic                 wr_en,
   input  wire logic [ADDR_BITS-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]     wr_data,
   input  wire logic                 rd_en,
   input  wire logic [ADDR_BITS-1:0] rd_addr,
   output logic      [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### rtl/edeng_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module edeng_ctrl (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   input  wire logic [edeng_pkg::OP_BITS-1:0] req_op,
   output logic                              req_ready,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   input  wire edeng_pkg::dpath_status_type  status,
   output edeng_pkg::ctrl_cmd_type           cmd
);
   import edeng_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_ROW   = 5'b00010,
      ST_CELL  = 5'b00100,
      ST_DRAIN = 5'b01000,
      ST_OUT   = 5'b10000
   } ctrl_state_type;

   ctrl_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           ready_out;
   ctrl_cmd_type   cmd_out;

   always_comb begin
      state_in     = state_ff;
      cmd_out      = '0;
      ready_out    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_IDLE: begin
            ready_out = 1'b1;
            if (req_valid) begin
               case (req_op)
                  OP_APPEND_FIRST:  cmd_out.append_first  = 1'b1;
                  OP_APPEND_SECOND: cmd_out.append_second = 1'b1;
                  OP_COMPUTE: begin
                     if (status.first_empty || status.second_empty) begin
                        cmd_out.trivial_load = 1'b1;
                        state_in             = ST_OUT;
                     end else begin
                        cmd_out.compute_start = 1'b1;
                        state_in              = ST_ROW;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_ROW: begin
            cmd_out.row_start = 1'b1;
            state_in          = ST_CELL;
         end
         ST_CELL: begin
            cmd_out.cell_issue = 1'b1;
            if (status.cell_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (status.row_last) begin
               state_in = ST_OUT;
            end else begin
               cmd_out.next_row = 1'b1;
               state_in         = ST_ROW;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd_out.result_load = 1'b1;
               rsp_valid_in        = 1'b1;
               state_in            = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = ready_out;
   assign rsp_valid = rsp_valid_ff;
   assign cmd       = cmd_out;

endmodule

`default_nettype wire

### rtl/edeng_dpath.sv
`timescale 1ns / 1ps
`default_nettype none

module edeng_dpath #(
   parameter int MAX_LEN     = edeng_pkg::MAX_LEN_DEFAULT,
   parameter int SYMBOL_BITS = edeng_pkg::SYMBOL_BITS_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic [edeng_pkg::SYMBOL_FIELD-1:0] req_symbol,
   input  wire edeng_pkg::ctrl_cmd_type           cmd,
   output edeng_pkg::dpath_status_type            status,
   output logic      [edeng_pkg::DIST_BITS-1:0]   rsp_distance,
   output logic                                   rsp_overflowed
);
   import edeng_pkg::*;

   localparam int LEN_BITS  = $clog2(MAX_LEN + 1);
   localparam int ADDR_BITS = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam int COST_BITS = LEN_BITS;

   // sequence lengths and overflow
   logic [LEN_BITS-1:0] n1_ff, n1_in;
   logic [LEN_BITS-1:0] n2_ff, n2_in;
   logic                ovf_ff, ovf_in;
   logic                n1_full, n2_full;

   // sweep counters and cell pipeline
   logic [LEN_BITS-1:0]  x_ff, x_in;
   logic [LEN_BITS-1:0]  y_ff, y_in;
   logic [LEN_BITS-1:0]  y_dec, x_dec;
   logic                 pipe_valid_ff;
   logic [LEN_BITS-1:0]  pipe_y_ff;
   logic [ADDR_BITS-1:0] pipe_addr_ff;
   logic [COST_BITS-1:0] left_ff, left_in;
   logic [COST_BITS-1:0] diag_ff, diag_in;

   logic [DIST_BITS-1:0] dist_ff, dist_in;
   logic                 ovf_out_ff;

   logic [SYMBOL_WIDE-1:0] sym_wide;
   logic [SYMBOL_BITS-1:0] sym_keep;
   logic [SYMBOL_BITS-1:0] first_rd, second_rd;
   logic [COST_BITS-1:0]   cost_rd;
   logic [ADDR_BITS-1:0]   cell_addr;

   logic [COST_BITS-1:0] up;
   logic [COST_BITS:0]   up_inc, left_inc, sub_cost, best_wide;
   logic [COST_BITS-1:0] best;
   logic [31:0]          left_wide;

   assign sym_wide  = SYMBOL_WIDE'(req_symbol);
   assign sym_keep  = sym_wide[SYMBOL_BITS-1:0];
   assign n1_full   = (n1_ff == LEN_BITS'(MAX_LEN));
   assign n2_full   = (n2_ff == LEN_BITS'(MAX_LEN));
   assign y_dec     = y_ff - LEN_BITS'(1);
   assign x_dec     = x_ff - LEN_BITS'(1);
   assign cell_addr = y_dec[ADDR_BITS-1:0];

   edeng_ram #(.WIDTH(SYMBOL_BITS), .DEPTH(MAX_LEN)) u_first_ram (
      .clock   (clock),
      .wr_en   (cmd.append_first && !n1_full),
      .wr_addr (n1_ff[ADDR_BITS-1:0]),
      .wr_data (sym_keep),
      .rd_en   (cmd.cell_issue),
      .rd_addr (cell_addr),
      .rd_data (first_rd)
   );

   edeng_ram #(.WIDTH(SYMBOL_BITS), .DEPTH(MAX_LEN)) u_second_ram (
      .clock   (clock),
      .wr_en   (cmd.append_second && !n2_full),
      .wr_addr (n2_ff[ADDR_BITS-1:0]),
      .wr_data (sym_keep),
      .rd_en   (cmd.row_start),
      .rd_addr (x_dec[ADDR_BITS-1:0]),
      .rd_data (second_rd)
   );

   edeng_ram #(.WIDTH(COST_BITS), .DEPTH(MAX_LEN)) u_cost_ram (
      .clock   (clock),
      .wr_en   (pipe_valid_ff),
      .wr_addr (pipe_addr_ff),
      .wr_data (best),
      .rd_en   (cmd.cell_issue),
      .rd_addr (cell_addr),
      .rd_data (cost_rd)
   );

   // first row reads the implicit initial row y
   assign up        = (x_ff == LEN_BITS'(1)) ? pipe_y_ff : cost_rd;
   assign up_inc    = {1'b0, up} + (COST_BITS + 1)'(1);
   assign left_inc  = {1'b0, left_ff} + (COST_BITS + 1)'(1);
   assign sub_cost  = {1'b0, diag_ff} + (COST_BITS + 1)'(first_rd != second_rd);

   always_comb begin
      best_wide = (up_inc < left_inc) ? up_inc : left_inc;
      if (sub_cost < best_wide) begin
         best_wide = sub_cost;
      end
   end

   assign best      = best_wide[COST_BITS-1:0];
   assign left_wide = 32'(left_ff);

   always_comb begin
      n1_in   = n1_ff;
      n2_in   = n2_ff;
      ovf_in  = ovf_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      left_in = left_ff;
      diag_in = diag_ff;
      dist_in = (left_wide > 32'(DIST_MAX)) ? DIST_BITS'(DIST_MAX) : left_wide[DIST_BITS-1:0];
      if (cmd.append_first) begin
         if (n1_full) begin
            ovf_in = 1'b1;
         end else begin
            n1_in = n1_ff + LEN_BITS'(1);
         end
      end
      if (cmd.append_second) begin
         if (n2_full) begin
            ovf_in = 1'b1;
         end else begin
            n2_in = n2_ff + LEN_BITS'(1);
         end
      end
      if (cmd.trivial_load) begin
         left_in = (n1_ff == '0) ? n2_ff : n1_ff;
      end
      if (cmd.compute_start) begin
         x_in = LEN_BITS'(1);
      end
      if (cmd.next_row) begin
         x_in = x_ff + LEN_BITS'(1);
      end
      if (cmd.row_start) begin
         y_in    = LEN_BITS'(1);
         left_in = x_ff;
         diag_in = x_dec;
      end
      if (cmd.cell_issue) begin
         y_in = y_ff + LEN_BITS'(1);
      end
      if (pipe_valid_ff) begin
         left_in = best;
         diag_in = up;
      end
      if (cmd.result_load) begin
         n1_in  = '0;
         n2_in  = '0;
         ovf_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         n1_ff         <= '0;
         n2_ff         <= '0;
         ovf_ff        <= 1'b0;
         pipe_valid_ff <= 1'b0;
      end else begin
         n1_ff         <= n1_in;
         n2_ff         <= n2_in;
         ovf_ff        <= ovf_in;
         pipe_valid_ff <= cmd.cell_issue;
      end
   end

   always_ff @(posedge clock) begin
      x_ff         <= x_in;
      y_ff         <= y_in;
      left_ff      <= left_in;
      diag_ff      <= diag_in;
      pipe_y_ff    <= y_ff;
      pipe_addr_ff <= cell_addr;
      if (cmd.result_load) begin
         dist_ff    <= dist_in;
         ovf_out_ff <= ovf_ff;
      end
   end

   assign status.first_empty  = (n1_ff == '0);
   assign status.second_empty = (n2_ff == '0);
   assign status.cell_last    = (y_ff == n1_ff);
   assign status.row_last     = (x_ff == n2_ff);

   assign rsp_distance   = dist_ff;
   assign rsp_overflowed = ovf_out_ff;

endmodule

`default_nettype wire

### rtl/edit_distance_engine_unit.sv
//  channel   dir   handshake          payload
//  req_bus   in    valid / ready      op, symbol
//  rsp_bus   out   valid / ready      distance, overflowed
//
//  a compute request with both sequences non-empty sweeps each row one cell per cycle
//  through the cost row memory
//  reset is synchronous and clears lengths, overflow flag and control state
//  requests are taken only while idle; a stalled result holds in the output register
`timescale 1ns / 1ps
`default_nettype none

module edit_distance_engine_unit #(
   parameter int MAX_LEN     = edeng_pkg::MAX_LEN_DEFAULT,
   parameter int SYMBOL_BITS = edeng_pkg::SYMBOL_BITS_DEFAULT
) (
   input wire logic        clock,
   input wire logic        reset,
   edeng_req_if.sink       req_bus,
   edeng_rsp_if.source     rsp_bus
);
   import edeng_pkg::*;

   ctrl_cmd_type     cmd;
   dpath_status_type status;

   edeng_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_op    (req_bus.op),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   edeng_dpath #(.MAX_LEN(MAX_LEN), .SYMBOL_BITS(SYMBOL_BITS)) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .req_symbol     (req_bus.symbol),
      .cmd            (cmd),
      .status         (status),
      .rsp_distance   (rsp_bus.distance),
      .rsp_overflowed (rsp_bus.overflowed)
   );

endmodule

`default_nettype wire

### rtl/edeng_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module edeng_checker #(
   parameter int MAX_LEN = edeng_pkg::MAX_LEN_DEFAULT
) (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           req_valid,
   input wire logic                           req_ready,
   input wire logic [edeng_pkg::OP_BITS-1:0]   req_op,
   input wire logic                           rsp_valid,
   input wire logic                           rsp_ready,
   input wire logic [edeng_pkg::DIST_BITS-1:0] rsp_distance,
   input wire logic                           rsp_overflowed
);
   import edeng_pkg::*;

   localparam int DIST_LIMIT = (MAX_LEN < DIST_MAX) ? MAX_LEN : DIST_MAX;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_distance) && $stable(rsp_overflowed))
      else $error("response payload changed while stalled");

   a_busy_after_compute: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_op == OP_COMPUTE) |=> !req_ready)
      else $error("request taken right after compute request");

   a_rsp_from_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("response raised without a compute in progress");

   a_dist_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (32'(rsp_distance) <= DIST_LIMIT))
      else $error("distance out of range");

endmodule

bind edit_distance_engine_unit edeng_checker #(.MAX_LEN(MAX_LEN)) u_edeng_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_bus.valid),
   .req_ready      (req_bus.ready),
   .req_op         (req_bus.op),
   .rsp_valid      (rsp_bus.valid),
   .rsp_ready      (rsp_bus.ready),
   .rsp_distance   (rsp_bus.distance),
   .rsp_overflowed (rsp_bus.overflowed)
);

`default_nettype wire
